### design/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, constants and the rotation angle table for the standing-wave
// cavity field pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package swc_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int STG_W      = $clog2(ANGLE_BITS);
   localparam int CW         = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
   localparam logic signed [32:0]   DZ_STEP     = 33'sd6554;

   localparam logic [2:0] CSR_AMPLITUDE = 3'd0;
   localparam logic [2:0] CSR_Z_RATE    = 3'd1;
   localparam logic [2:0] CSR_FREQ      = 3'd2;
   localparam logic [2:0] CSR_T_OFFSET  = 3'd3;
   localparam logic [2:0] CSR_B_SCALE   = 3'd4;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [47:0] time_req;
   } req_type;

   typedef struct packed {
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] e_x;
      logic signed [31:0] e_y;
      logic signed [31:0] e_z;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] a;
      logic                 flip;
   } cord_type;

   function automatic logic [31:0] atan_turns(input logic [STG_W-1:0] idx);
      logic [31:0] r;
      case (5'(idx))
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;  default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -80'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### design/swc_cell.sv
// ----------------------------------------------------------------------------
// swc_cell
// One rotation step of the phase-to-cosine/sine chain, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module swc_cell
   import swc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire logic [STG_W-1:0] stage_idx,
   input  wire cord_type         d,
   output cord_type              q
);
   cord_type q_ff, q_in;
   logic signed [CW-1:0] dx, dy, at;

   always_comb begin
      dx = d.y >>> stage_idx;
      dy = d.x >>> stage_idx;
      at = CW'(atan_turns(stage_idx));
      q_in.flip = d.flip;
      if (!d.a[CW-1]) begin
         q_in.x = d.x - dx;
         q_in.y = d.y + dy;
         q_in.a = d.a - at;
      end else begin
         q_in.x = d.x + dx;
         q_in.y = d.y - dy;
         q_in.a = d.a + at;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) q_ff <= q_in;
   end

   assign q = q_ff;
endmodule
`default_nettype wire

### design/standing_wave_cavity_field_core.sv
// ----------------------------------------------------------------------------
// standing_wave_cavity_field_core
// Paraxial standing-wave cavity field: E and B at a point and a time.
// ----------------------------------------------------------------------------
// The core takes one word per cycle unless a result is stalled and returns one
// word per word, in order. Three stages form the time and axial phases, a chain
// of ANGLE_BITS rotation cells per phase (time, z, z + 0.1 mm, z - 0.1 mm) gives
// cosine and sine, and three multiply stages plus the output register form the
// fields. The whole pipeline holds while a result is stalled.
`default_nettype none
module standing_wave_cavity_field_core
   import swc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_data
);
   localparam int SL = ANGLE_BITS + 6;

   logic signed [31:0] amp_ff, bsc_ff;
   logic [31:0]        zrate_ff, freq_ff;
   logic [47:0]        toff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '0; zrate_ff <= '0; freq_ff <= '0; toff_ff <= '0; bsc_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AMPLITUDE: amp_ff   <= csr_data[31:0];
            CSR_Z_RATE:    zrate_ff <= csr_data[31:0];
            CSR_FREQ:      freq_ff  <= csr_data[31:0];
            CSR_T_OFFSET:  toff_ff  <= csr_data;
            CSR_B_SCALE:   bsc_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Valid bits and the transverse position travel beside the data stages.
   logic               vld_ff [SL];
   logic signed [31:0] sx_ff  [SL];
   logic signed [31:0] sy_ff  [SL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SL; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < SL; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0] <= req_data.pos_x;
         sy_ff[0] <= req_data.pos_y;
         for (int k = 1; k < SL; k++) begin
            sx_ff[k] <= sx_ff[k-1];
            sy_ff[k] <= sy_ff[k-1];
         end
      end
   end

   // Stage A: position and time difference.
   logic signed [31:0] z_ff;
   logic [47:0]        dt_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff  <= req_data.pos_z;
         dt_ff <= req_data.time_req - toff_ff;
      end
   end

   // Stage B: phase products, wrapped to 48 bits.
   logic signed [32:0] zc, zp, zm, rate_s;
   logic signed [65:0] pzc, pzp, pzm;
   logic [47:0] pz_ff, pzp_ff, pzm_ff, ptl_ff;
   logic [15:0] pth_ff;
   logic [63:0] ptl;
   logic [47:0] pth;
   always_comb begin
      zc     = 33'(z_ff);
      zp     = zc + DZ_STEP;
      zm     = zc - DZ_STEP;
      rate_s = {1'b0, zrate_ff};
      pzc    = zc * rate_s;
      pzp    = zp * rate_s;
      pzm    = zm * rate_s;
      ptl    = dt_ff[31:0] * freq_ff;
      pth    = dt_ff[47:32] * freq_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pz_ff  <= pzc[47:0];
         pzp_ff <= pzp[47:0];
         pzm_ff <= pzm[47:0];
         ptl_ff <= ptl[47:0];
         pth_ff <= pth[15:0];
      end
   end

   // Stage C: phases, quadrant fold and the start of each rotation chain.
   function automatic cord_type seed(input logic [31:0] ph_raw);
      logic [31:0] ph;
      cord_type    c;
      ph     = ph_raw & ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
      c.flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      if (c.flip) ph = ph + 32'h80000000;
      c.a = CW'($signed(ph));
      c.x = CORDIC_GAIN;
      c.y = '0;
      return c;
   endfunction

   cord_type chain [4][ANGLE_BITS+1];
   cord_type seed_ff [4];
   logic [31:0] tph;
   assign tph = ptl_ff[47:16] + {pth_ff, 16'h0000};

   always_ff @(posedge clock) begin
      if (adv) begin
         seed_ff[0] <= seed(tph);
         seed_ff[1] <= seed(pz_ff[47:16]);
         seed_ff[2] <= seed(pzp_ff[47:16]);
         seed_ff[3] <= seed(pzm_ff[47:16]);
      end
   end

   genvar r, i;
   generate
      for (r = 0; r < 4; r++) begin : g_row
         assign chain[r][0] = seed_ff[r];
         for (i = 0; i < ANGLE_BITS; i++) begin : g_cell
            swc_cell u_cell (
               .clock     (clock),
               .adv       (adv),
               .stage_idx (STG_W'(i)),
               .d         (chain[r][i]),
               .q         (chain[r][i+1])
            );
         end
      end
   endgenerate

   // Stage D1: cosine products and the axial cosine by time sine product.
   logic signed [CW-1:0] cv [4];
   logic signed [CW-1:0] st;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cv[k] = chain[k][ANGLE_BITS].flip ? -chain[k][ANGLE_BITS].x
                                           : chain[k][ANGLE_BITS].x;
      end
      st = chain[0][ANGLE_BITS].flip ? -chain[0][ANGLE_BITS].y : chain[0][ANGLE_BITS].y;
   end

   logic signed [2*CW-1:0] p_cc, p_ccp, p_ccm, p_cs;
   logic signed [CW-1:0]   cc_ff, ccp_ff, ccm_ff, cs_ff;
   assign p_cc  = cv[1] * cv[0];
   assign p_ccp = cv[2] * cv[0];
   assign p_ccm = cv[3] * cv[0];
   assign p_cs  = cv[1] * st;
   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff  <= p_cc[CW+29:30];
         ccp_ff <= p_ccp[CW+29:30];
         ccm_ff <= p_ccm[CW+29:30];
         cs_ff  <= p_cs[CW+29:30];
      end
   end

   // Stage D2: scale by the amplitude registers.
   logic signed [CW+31:0] p_ez, p_ezp, p_ezm, p_m;
   logic signed [31:0]    ez_ff, ezp_ff, ezm_ff, m_ff;
   assign p_ez  = amp_ff * cc_ff;
   assign p_ezp = amp_ff * ccp_ff;
   assign p_ezm = amp_ff * ccm_ff;
   assign p_m   = bsc_ff * cs_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ez_ff  <= sat32(80'(p_ez >>> 30));
         ezp_ff <= sat32(80'(p_ezp >>> 30));
         ezm_ff <= sat32(80'(p_ezm >>> 30));
         m_ff   <= sat32(80'(p_m >>> 30));
      end
   end

   // Stage D3: axial gradient by central difference.
   logic signed [32:0] ediff;
   logic signed [31:0] g_ff, ez3_ff, m3_ff;
   assign ediff = 33'(ezp_ff) - 33'(ezm_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff   <= sat32(80'(ediff) * 80'sd5);
         ez3_ff <= ez_ff;
         m3_ff  <= m_ff;
      end
   end

   // Output register: transverse projections.
   logic signed [31:0] xo, yo;
   logic signed [64:0] p_xg, p_yg, p_ym, p_xm;
   rsp_type rsp_ff, rsp_in;
   logic    rv_ff;
   always_comb begin
      xo = sx_ff[SL-1];
      yo = sy_ff[SL-1];
      p_xg = -(65'(xo) * 65'(g_ff));
      p_yg = -(65'(yo) * 65'(g_ff));
      p_ym = 65'(yo) * 65'(m3_ff);
      p_xm = -(65'(xo) * 65'(m3_ff));
      rsp_in.b_x = sat32(80'(p_ym >>> 24));
      rsp_in.b_y = sat32(80'(p_xm >>> 24));
      rsp_in.b_z = '0;
      rsp_in.e_x = sat32(80'(p_xg >>> 17));
      rsp_in.e_y = sat32(80'(p_yg >>> 17));
      rsp_in.e_z = ez3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= vld_ff[SL-1];
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   a_stall_rule: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output stall");

   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[SL-1]) |=> rsp_valid)
      else $error("a word at the last stage did not reach the output");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data) && $stable(vld_ff[0])))
      else $error("pipeline moved while the output was stalled");
endmodule
`default_nettype wire

### tb/standing_wave_cavity_field_core_tb.sv
// ----------------------------------------------------------------------------
// standing_wave_cavity_field_core_tb
// Streams points and times through the cavity field core under several
// register settings. Each result is compared field by field with a fixed-point
// field model kept inside the bench. Sender bursts and receiver stalls are
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module standing_wave_cavity_field_core_tb
   import swc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   class field_scoreboard;
      longint           amp;
      bit [31:0]        z_rate;
      bit [31:0]        freq;
      longint           t_offset;
      longint           b_scale;
      rsp_type          pending_fields[$];
      int unsigned      errors;
      int unsigned      words_checked;
      bit [31:0]        atan_tab[32];

      function new();
         atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
         amp = 0; z_rate = 0; freq = 0; t_offset = 0; b_scale = 0;
         errors = 0; words_checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [47:0] value);
         case (idx)
            CSR_AMPLITUDE: amp = longint'($signed(value[31:0]));
            CSR_Z_RATE:    z_rate = value[31:0];
            CSR_FREQ:      freq = value[31:0];
            CSR_T_OFFSET:  t_offset = longint'($signed(value));
            CSR_B_SCALE:   b_scale = longint'($signed(value[31:0]));
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Rotation in turns; the second and third quadrants are folded by half a turn.
      function void rotate(bit [31:0] ph, output longint c, output longint s);
         longint x, y, a, dx, dy;
         bit flip;
         ph = ph & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
         flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
         if (flip) ph = ph + 32'h8000_0000;
         a = longint'($signed(ph));
         x = 652032874;
         y = 0;
         for (int i = 0; i < ANGLE_BITS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
               x = x - dx; y = y + dy; a = a - longint'(atan_tab[i]);
            end else begin
               x = x + dx; y = y - dy; a = a + longint'(atan_tab[i]);
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function bit [31:0] axial_turns(bit [63:0] zu);
         bit [63:0] p;
         p = zu * {32'b0, z_rate};
         return p[47:16];
      endfunction

      function longint axial_field(bit [63:0] zu, longint ct);
         longint cz, sz;
         rotate(axial_turns(zu), cz, sz);
         return clamp32(amp * ((cz * ct) >>> 30) >>> 30);
      endfunction

      function void note(req_type d);
         rsp_type   r;
         bit [63:0] zu, dt, tp;
         longint    x, y, ct, st, cz, sz, ez, g, m;
         x = longint'(d.pos_x);
         y = longint'(d.pos_y);
         zu = longint'(d.pos_z);
         dt = longint'(d.time_req) - t_offset;
         tp = dt * {32'b0, freq};
         rotate(tp[47:16], ct, st);
         ez = axial_field(zu, ct);
         g = clamp32(5 * (axial_field(zu + 64'd6554, ct) - axial_field(zu - 64'd6554, ct)));
         rotate(axial_turns(zu), cz, sz);
         m = clamp32(b_scale * ((cz * st) >>> 30) >>> 30);
         r.b_x = 32'(clamp32((y * m) >>> 24));
         r.b_y = 32'(clamp32((-(x * m)) >>> 24));
         r.b_z = '0;
         r.e_x = 32'(clamp32((-(x * g)) >>> 17));
         r.e_y = 32'(clamp32((-(y * g)) >>> 17));
         r.e_z = 32'(ez);
         pending_fields.push_back(r);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            errors++;
         end
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (pending_fields.size() == 0) begin
            $error("result word with no expectation waiting");
            errors++;
            return;
         end
         want = pending_fields.pop_front();
         words_checked++;
         compare("b_x", want.b_x, got.b_x);
         compare("b_y", want.b_y, got.b_y);
         compare("b_z", want.b_z, got.b_z);
         compare("e_x", want.e_x, got.e_x);
         compare("e_y", want.e_y, got.e_y);
         compare("e_z", want.e_z, got.e_z);
      endfunction
   endclass

   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int RANDOM_WORDS = 1530;
   localparam longint CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   field_scoreboard sb = new();
   longint      cycles = 0;
   int          burst_left = 0;
   int unsigned stall_mode = 0;
   int unsigned configs_run = 0;

   standing_wave_cavity_field_core DUT (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver stall pattern changes character periodically, picked at random.
   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (cycles % 7) < 2;
      endcase
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);

   task automatic send_word(req_type d);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(d);
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending_fields.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 32'h000F_FFFF);
         4: return -$urandom_range(0, 32'h000F_FFFF);
         default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   function automatic req_type random_word();
      req_type d;
      d.pos_x = pick32();
      d.pos_y = pick32();
      d.pos_z = pick32();
      d.time_req = ($urandom_range(0, 1) == 0) ? 48'({$urandom, $urandom})
                                                : 48'($signed(pick32()));
      return d;
   endfunction

   task automatic load_config(logic [31:0] a, logic [31:0] zr, logic [31:0] f,
                              logic [47:0] off, logic [31:0] s);
      write_reg(CSR_AMPLITUDE, 48'($signed(a)));
      write_reg(CSR_Z_RATE, {16'hFFFF, zr});
      write_reg(CSR_FREQ, {16'h0, f});
      write_reg(CSR_T_OFFSET, off);
      write_reg(CSR_B_SCALE, {16'h0, s});
      // The spare index must be ignored by the core.
      write_reg(CSR_SPARE, 48'({$urandom, $urandom}));
      csr_write <= 1'b0;
      configs_run++;
   endtask

   initial begin
      req_type d;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: every field must come out zero.
      d = '0;
      send_word(d);
      d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF};
      send_word(d);
      drain();

      load_config(32'h0001_0000, 32'h0400_0000, 32'h0100_0000, 48'd0, 32'h0100_0000);
      // Directed: extremes of each field, the axis point, z at the wrap edge.
      send_word('{32'd0, 32'd0, 32'd0, 48'd0});
      send_word('{32'd0, 32'd0, 32'h0001_0000, 48'h0000_0001_0000});
      send_word('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF});
      send_word('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000});
      send_word('{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_E66A, 48'hFFFF_FFFF_FFFF});
      send_word('{32'h0001_0000, 32'hFFFF_0000, 32'h8000_1999, 48'h0000_0000_4000});
      send_word('{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 48'h0000_0000_0001});
      drain();

      // Register extremes, including saturation of every product.
      load_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                  32'h7FFF_FFFF);
      for (int i = 0; i < 8; i++) send_word(random_word());
      drain();
      load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000,
                  32'h8000_0000);
      for (int i = 0; i < 8; i++) send_word(random_word());
      drain();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 170 == 0) begin
            drain();
            load_config(pick32(), $urandom, $urandom, 48'({$urandom, $urandom}),
                        pick32());
         end
         send_word(random_word());
      end
      drain();
      repeat (ANGLE_BITS + 20) @(posedge clock);

      if (sb.pending_fields.size() != 0) begin
         $error("%0d expected words never arrived", sb.pending_fields.size());
         sb.errors++;
      end
      $display("Checked %0d result words over %0d register settings.",
               sb.words_checked, configs_run + 1);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
